// ===== sv/dbrf_pkg.sv =====
// Package for the transmit bucket reuse finder: sizes, codes, marker word,
// memory access structs and the ring increment. No dependencies.
`timescale 1ns / 1ps

package dbrf_pkg;

    localparam int BUCKETS = 64;
    localparam int IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int OP_W    = 2;
    localparam int SEL_W   = 8;
    localparam int LEN_W   = 16;
    localparam int TRL_W   = 64;
    localparam int STAT_W  = 2;

    localparam logic [SEL_W:0]   BUCKET_LIMIT = BUCKETS[SEL_W:0];
    localparam logic [TRL_W-1:0] MARKER_WORD  = 64'hDEAD_BEEF_DEAD_BEEF;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK   = 2'd2;
    localparam logic [OP_W-1:0] OP_GET   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNUSED  = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic              len_we;
        logic              trl_we;
        idx_t              addr;
        logic [LEN_W-1:0]  len;
        logic [TRL_W-1:0]  trl;
    } wr_req_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [TRL_W-1:0]  trl;
    } rd_data_t;

    function automatic idx_t idx_inc(input idx_t p);
        return (p == idx_t'(BUCKETS - 1)) ? '0 : p + idx_t'(1);
    endfunction

endpackage

// ===== sv/dbrf_if.sv =====
// Valid/ready channel interfaces for the request and response transfers.
// Depends on dbrf_pkg.
`timescale 1ns / 1ps

interface dbrf_in_if;
    import dbrf_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [SEL_W-1:0]    bucket_sel;
    logic [LEN_W-1:0]    payload_len;
    logic [TRL_W-1:0]    trailer_value;
    logic                room_ok;

    modport source (
        output valid, operation, bucket_sel, payload_len, trailer_value, room_ok,
        input  ready
    );

    modport sink (
        input  valid, operation, bucket_sel, payload_len, trailer_value, room_ok,
        output ready
    );
endinterface

interface dbrf_out_if;
    import dbrf_pkg::*;

    logic                valid;
    logic                ready;
    logic [SEL_W-1:0]    found_index;
    logic [STAT_W-1:0]   status;
    logic                anomaly_seen;

    modport source (
        output valid, found_index, status, anomaly_seen,
        input  ready
    );

    modport sink (
        input  valid, found_index, status, anomaly_seen,
        output ready
    );
endinterface

// ===== sv/dbrf_store.sv =====
// Bucket store: length and trailer memories with a registered read,
// plus per-entry valid bits so that reset and clear take effect at once.
// Depends on dbrf_pkg.
`timescale 1ns / 1ps

module dbrf_store (
    input  logic              clk,
    input  logic              rst_n,
    input  dbrf_pkg::wr_req_t wr,
    input  logic              clear_all,
    input  dbrf_pkg::idx_t    rd_addr,
    output dbrf_pkg::rd_data_t rd_data
);
    import dbrf_pkg::*;

    logic [LEN_W-1:0] len_mem [BUCKETS];
    logic [TRL_W-1:0] trl_mem [BUCKETS];

    logic [BUCKETS-1:0] valid_reg;
    logic               rd_valid_reg;
    logic [LEN_W-1:0]   rd_len_reg;
    logic [TRL_W-1:0]   rd_trl_reg;

    logic               len_we_eff;
    logic [LEN_W-1:0]   len_wdata;

    // A trailer write to an entry never written must also zero its length.
    assign len_we_eff = wr.len_we | (wr.trl_we & ~valid_reg[wr.addr]);
    assign len_wdata  = wr.len_we ? wr.len : '0;

    always_ff @(posedge clk)
    begin
        if (len_we_eff)
        begin
            len_mem[wr.addr] <= len_wdata;
        end
        if (wr.trl_we)
        begin
            trl_mem[wr.addr] <= wr.trl;
        end
        rd_len_reg <= len_mem[rd_addr];
        rd_trl_reg <= trl_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr.len_we | wr.trl_we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= ~clear_all & valid_reg[rd_addr];
        end
    end

    assign rd_data.len = rd_valid_reg ? rd_len_reg : '0;
    assign rd_data.trl = rd_valid_reg ? rd_trl_reg : '0;

endmodule

// ===== sv/dma_bucket_reuse_finder.sv =====
// Top level of the transmit bucket reuse finder: request decode, ring scan
// sequencer and response register. Depends on dbrf_pkg, dbrf_if, dbrf_store.
`timescale 1ns / 1ps

// Clear, mark_sent and dma_ack need no scan: their response is registered as
// the request is accepted. Clear takes effect at once through per-bucket valid
// bits, so there is no clearing pass. A get_free reads one bucket per cycle from
// the store memories, pipelined behind their registered read, and checks up to
// BUCKETS buckets in a full round that finds nothing. The response register
// holds a result until it is taken, and the next request is accepted in the
// same cycle as that transfer. One request is in work at a time.
module dma_bucket_reuse_finder (
    input  logic       clk,
    input  logic       rst_n,
    dbrf_in_if.sink    req,
    dbrf_out_if.source rsp
);
    import dbrf_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t             state_reg;
    idx_t               ptr_reg;
    idx_t               chk_ptr_reg;
    idx_t               iss_ptr_reg;
    idx_t               cnt_reg;
    logic               room_reg;
    logic               anom_acc_reg;
    logic               out_valid_reg;
    logic [SEL_W-1:0]   found_reg;
    logic [STAT_W-1:0]  status_reg;
    logic               anomaly_reg;

    logic     req_fire;
    logic     rsp_fire;
    logic     out_valid_next;
    logic     sel_ok;
    idx_t     sel_idx;
    wr_req_t  wr;
    logic     clear_all;
    idx_t     rd_addr;
    rd_data_t rd_data;
    logic     len_zero;
    logic     trl_zero;
    logic     is_free;
    logic     need_clr;
    logic     anom_now;
    logic     last_check;

    assign req.ready = (state_reg == S_IDLE) & (~out_valid_reg | rsp.ready);
    assign req_fire  = req.valid & req.ready;
    assign rsp_fire  = out_valid_reg & rsp.ready;

    assign sel_ok  = {1'b0, req.bucket_sel} < BUCKET_LIMIT;
    assign sel_idx = req.bucket_sel[IDX_W-1:0];

    assign len_zero   = (rd_data.len == '0);
    assign trl_zero   = (rd_data.trl == '0);
    assign is_free    = len_zero | trl_zero;
    assign need_clr   = ~len_zero & trl_zero;
    assign anom_now   = ~len_zero & ~trl_zero & (rd_data.trl != MARKER_WORD);
    assign last_check = (cnt_reg == idx_t'(BUCKETS - 1));

    assign out_valid_next = (out_valid_reg & ~rsp_fire)
                          | ((state_reg == S_IDLE) & req_fire & (req.operation != OP_GET))
                          | ((state_reg == S_SCAN) & (is_free | last_check));

    assign rd_addr   = (state_reg == S_SCAN) ? iss_ptr_reg : ptr_reg;
    assign clear_all = req_fire & (req.operation == OP_CLEAR);

    always_comb
    begin
        wr = '0;
        if (state_reg == S_SCAN)
        begin
            if (need_clr)
            begin
                wr.len_we = 1'b1;
                wr.addr   = chk_ptr_reg;
            end
        end
        else if (req_fire && sel_ok)
        begin
            unique case (req.operation)
                OP_MARK:
                begin
                    wr.len_we = 1'b1;
                    wr.trl_we = 1'b1;
                    wr.addr   = sel_idx;
                    wr.len    = req.payload_len;
                    wr.trl    = MARKER_WORD;
                end
                OP_ACK:
                begin
                    wr.trl_we = 1'b1;
                    wr.addr   = sel_idx;
                    wr.trl    = req.trailer_value;
                end
                OP_CLEAR, OP_GET:
                begin
                    wr = '0;
                end
                default:
                begin
                    wr = '0;
                end
            endcase
        end
    end

    dbrf_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .clear_all (clear_all),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            chk_ptr_reg   <= '0;
            iss_ptr_reg   <= '0;
            cnt_reg       <= '0;
            room_reg      <= 1'b0;
            anom_acc_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= '0;
            status_reg    <= ST_OK;
            anomaly_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        if (req.operation == OP_GET)
                        begin
                            state_reg    <= S_SCAN;
                            chk_ptr_reg  <= ptr_reg;
                            iss_ptr_reg  <= idx_inc(ptr_reg);
                            cnt_reg      <= '0;
                            room_reg     <= req.room_ok;
                            anom_acc_reg <= 1'b0;
                        end
                        else
                        begin
                            found_reg     <= '0;
                            status_reg    <= ST_OK;
                            anomaly_reg   <= 1'b0;
                            if (req.operation == OP_CLEAR)
                            begin
                                ptr_reg <= '0;
                            end
                        end
                    end
                end
                S_SCAN:
                begin
                    iss_ptr_reg <= idx_inc(iss_ptr_reg);
                    if (is_free)
                    begin
                        state_reg     <= S_IDLE;
                        anomaly_reg   <= anom_acc_reg;
                        if (room_reg)
                        begin
                            found_reg  <= SEL_W'(chk_ptr_reg);
                            status_reg <= ST_OK;
                            ptr_reg    <= idx_inc(chk_ptr_reg);
                        end
                        else
                        begin
                            found_reg  <= '0;
                            status_reg <= ST_NO_ROOM;
                            ptr_reg    <= chk_ptr_reg;
                        end
                    end
                    else if (last_check)
                    begin
                        state_reg     <= S_IDLE;
                        found_reg     <= '0;
                        status_reg    <= ST_NO_FREE;
                        anomaly_reg   <= anom_acc_reg | anom_now;
                    end
                    else
                    begin
                        cnt_reg      <= cnt_reg + idx_t'(1);
                        chk_ptr_reg  <= iss_ptr_reg;
                        anom_acc_reg <= anom_acc_reg | anom_now;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found_index  = found_reg;
    assign rsp.status       = status_reg;
    assign rsp.anomaly_seen = anomaly_reg;

`ifndef ASSERT_OFF
    a_no_unused_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg != ST_UNUSED))
        else $error("response carries the unused status code");

    a_index_only_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |-> (found_reg == '0))
        else $error("bucket index reported without a grant");

    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.operation == OP_GET)) |=> (state_reg == S_SCAN))
        else $error("get_free transfer did not start a scan");

    a_scan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !out_valid_reg)
        else $error("scan running while a response is still pending");

    a_pointer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_reg <= idx_t'(BUCKETS - 1)) && (chk_ptr_reg <= idx_t'(BUCKETS - 1)))
        else $error("scan pointer left the ring");
`endif

endmodule

// ===== sim/dbrf_checker.sv =====
// Result checker for the transmit bucket reuse finder: watches both channels,
// tracks the bucket ring state and compares every result transfer.
// Depends on dbrf_pkg and dbrf_if.
`timescale 1ns / 1ps

module dbrf_checker
    import dbrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dbrf_in_if          req,
    dbrf_out_if         rsp,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    typedef struct packed {
        logic [SEL_W-1:0]  found_index;
        logic [STAT_W-1:0] status;
        logic              anomaly_seen;
    } outcome_t;

    logic [LEN_W-1:0] bucket_len [BUCKETS];
    logic [TRL_W-1:0] bucket_trl [BUCKETS];
    int unsigned      scan_ptr;
    outcome_t         pending_outcomes [$];
    int unsigned      miss_count = 0;

    function automatic void wipe_ring();
        for (int i = 0; i < BUCKETS; i++)
        begin
            bucket_len[i] = '0;
            bucket_trl[i] = '0;
        end
        scan_ptr = 0;
    endfunction

    function automatic outcome_t predict_outcome(
        input logic [OP_W-1:0]  op,
        input logic [SEL_W-1:0] sel,
        input logic [LEN_W-1:0] len,
        input logic [TRL_W-1:0] trl,
        input logic             room
    );
        outcome_t    o;
        int unsigned p;
        bit          hit;
        o = '0;
        o.status = ST_OK;
        hit = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                wipe_ring();
            end
            OP_MARK:
            begin
                if (sel < BUCKETS)
                begin
                    bucket_len[sel] = len;
                    bucket_trl[sel] = MARKER_WORD;
                end
            end
            OP_ACK:
            begin
                if (sel < BUCKETS)
                    bucket_trl[sel] = trl;
            end
            OP_GET:
            begin
                p = scan_ptr % BUCKETS;
                for (int n = 0; n < BUCKETS && !hit; n++)
                begin
                    if (bucket_len[p] == '0)
                        hit = 1'b1;
                    else if (bucket_trl[p] == '0)
                    begin
                        bucket_len[p] = '0;
                        hit = 1'b1;
                    end
                    else
                    begin
                        if (bucket_trl[p] != MARKER_WORD)
                            o.anomaly_seen = 1'b1;
                        p = (p + 1) % BUCKETS;
                    end
                end
                if (!hit)
                begin
                    o.status = ST_NO_FREE;
                    scan_ptr = p;
                end
                else if (room)
                begin
                    o.found_index = SEL_W'(p);
                    scan_ptr = (p + 1) % BUCKETS;
                end
                else
                begin
                    o.status = ST_NO_ROOM;
                    scan_ptr = p;
                end
            end
        endcase
        return o;
    endfunction

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            wipe_ring();
            pending_outcomes.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.found_index  = rsp.found_index;
                got.status       = rsp.status;
                got.anomaly_seen = rsp.anomaly_seen;
                if (pending_outcomes.size() == 0)
                begin
                    if (miss_count < 10)
                        $display("%0t: result transfer with nothing expected: index %0d status %0d anomaly %0d",
                                 $time, got.found_index, got.status, got.anomaly_seen);
                    miss_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got.found_index !== want.found_index || got.status !== want.status ||
                        got.anomaly_seen !== want.anomaly_seen)
                    begin
                        if (miss_count < 10)
                            $display("%0t: expected index %0d status %0d anomaly %0d, got index %0d status %0d anomaly %0d",
                                     $time, want.found_index, want.status, want.anomaly_seen,
                                     got.found_index, got.status, got.anomaly_seen);
                        miss_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                pending_outcomes.push_back(predict_outcome(req.operation, req.bucket_sel,
                                                           req.payload_len, req.trailer_value,
                                                           req.room_ok));
        end
        mismatches  <= miss_count;
        outstanding <= pending_outcomes.size();
    end

endmodule

// ===== sim/dma_bucket_reuse_finder_test.sv =====
// Testbench top for the transmit bucket reuse finder: clock, reset, request
// stimulus, result stalls and the verdict. Depends on dbrf_pkg, dbrf_if,
// dbrf_checker and the block itself.
`timescale 1ns / 1ps

module dma_bucket_reuse_finder_test;
    import dbrf_pkg::*;

    localparam int unsigned STIM_ITEMS = 1650;
    localparam int unsigned CALM_TAIL  = 150;

    logic        clk;
    logic        rst_n;
    bit          calm = 1'b0;
    int unsigned sent = 0;
    int unsigned mismatches;
    int unsigned outstanding;

    dbrf_in_if  req_ch ();
    dbrf_out_if rsp_ch ();

    dma_bucket_reuse_finder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dbrf_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [TRL_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TRL_W-1:0] pick_trailer();
        case ($urandom_range(0, 5))
            0, 1, 2: return '0;
            3:       return MARKER_WORD;
            4:       return '1;
            default: return rand_word();
        endcase
    endfunction

    task automatic send_item(
        input logic [OP_W-1:0]  op,
        input logic [SEL_W-1:0] sel,
        input logic [LEN_W-1:0] len,
        input logic [TRL_W-1:0] trl,
        input logic             room
    );
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.bucket_sel    <= sel;
        req_ch.payload_len   <= len;
        req_ch.trailer_value <= trl;
        req_ch.room_ok       <= room;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent++;
        if (sent >= STIM_ITEMS - CALM_TAIL)
            calm = 1'b1;
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        int unsigned burst;
        int unsigned pick;
        bit          drained_once;
        drained_once = 1'b0;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.operation     <= OP_CLEAR;
        req_ch.bucket_sel    <= '0;
        req_ch.payload_len   <= '0;
        req_ch.trailer_value <= '0;
        req_ch.room_ok       <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_item(OP_GET, '0, '0, '0, 1'b1);
        send_item(OP_MARK, 8'd1, '1, rand_word(), 1'b1);
        send_item(OP_MARK, 8'd2, '0, rand_word(), 1'b0);
        send_item(OP_MARK, 8'd255, 16'd7, '0, 1'b1);
        send_item(OP_ACK, SEL_W'(BUCKETS), '1, '1, 1'b1);
        send_item(OP_MARK, SEL_W'(BUCKETS - 1), 16'd1, '0, 1'b0);
        send_item(OP_ACK, SEL_W'(BUCKETS - 1), '0, '1, 1'b0);
        send_item(OP_MARK, 8'd3, 16'd100, '0, 1'b1);
        send_item(OP_ACK, 8'd3, '0, '0, 1'b1);
        send_item(OP_GET, '0, '0, '0, 1'b1);
        send_item(OP_GET, '0, '0, '0, 1'b0);
        send_item(OP_GET, '0, '0, '0, 1'b1);
        send_item(OP_ACK, 8'd1, '0, MARKER_WORD, 1'b1);
        send_item(OP_CLEAR, '1, '1, '1, 1'b1);
        send_item(OP_GET, '0, '0, '0, 1'b0);

        while (sent < STIM_ITEMS)
        begin
            if (!drained_once && sent >= STIM_ITEMS / 2)
            begin
                wait_for_results();
                drained_once = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                // Fill the whole ring so scans run a full round.
                for (int k = 0; k < BUCKETS; k++)
                    send_item(OP_MARK, SEL_W'(k), LEN_W'($urandom_range(1, 65535)),
                              rand_word(), 1'($urandom));
                burst = $urandom_range(0, 3);
                for (int k = 0; k < burst; k++)
                    send_item(OP_ACK, SEL_W'($urandom_range(0, BUCKETS - 1)), LEN_W'($urandom),
                              rand_word(), 1'($urandom));
                send_item(OP_GET, SEL_W'($urandom), LEN_W'($urandom), rand_word(), 1'($urandom));
                send_item(OP_GET, SEL_W'($urandom), LEN_W'($urandom), rand_word(), 1'($urandom));
                burst = $urandom_range(0, 4);
                for (int k = 0; k < burst; k++)
                    send_item(OP_ACK, SEL_W'($urandom_range(0, BUCKETS - 1)), LEN_W'($urandom),
                              '0, 1'($urandom));
                burst = $urandom_range(1, 6);
                for (int k = 0; k < burst; k++)
                    send_item(OP_GET, SEL_W'($urandom), LEN_W'($urandom), rand_word(),
                              1'($urandom_range(0, 3) != 0));
            end
            else if (pick < 55)
            begin
                burst = $urandom_range(8, 24);
                for (int k = 0; k < burst; k++)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3:
                            send_item(OP_GET, SEL_W'($urandom), LEN_W'($urandom), rand_word(),
                                      1'($urandom_range(0, 3) != 0));
                        4, 5, 6:
                            send_item(OP_MARK, SEL_W'($urandom_range(0, BUCKETS - 1)),
                                      ($urandom_range(0, 7) == 0) ? '0 : LEN_W'($urandom),
                                      rand_word(), 1'($urandom));
                        default:
                            send_item(OP_ACK, SEL_W'($urandom_range(0, BUCKETS - 1)),
                                      LEN_W'($urandom), pick_trailer(), 1'($urandom));
                    endcase
                end
            end
            else if (pick < 60)
            begin
                send_item(OP_CLEAR, SEL_W'($urandom), LEN_W'($urandom), rand_word(),
                          1'($urandom));
            end
            else
            begin
                burst = $urandom_range(1, 4);
                for (int k = 0; k < burst; k++)
                    send_item(OP_W'($urandom), SEL_W'($urandom), LEN_W'($urandom), rand_word(),
                              1'($urandom));
            end
        end

        wait_for_results();
        repeat (BUCKETS + 8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
